// ===== rtl/core/triangle_overlap_cull_defines.svh =====
// ----------------------------------------------------------------------------
// Triangle overlap cull: assertion macros
// Shared concurrent-assertion wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_OVERLAP_CULL_DEFINES_SVH
`define TRIANGLE_OVERLAP_CULL_DEFINES_SVH

// property must hold on every edge outside reset
`define TOC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be seen outside reset
`define TOC_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== rtl/core/toc_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle overlap cull: package
// Shared widths, defaults and the sequencer state type.
// ----------------------------------------------------------------------------
package toc_pkg;

  localparam int unsigned DEF_MAX_TRIANGLES = 64;
  localparam int unsigned DEF_MAX_POINTS    = 256;
  localparam int unsigned DEF_COORD_BITS    = 24;

  localparam int unsigned VERT_W    = 8;
  localparam int unsigned RAD_W     = 23;
  localparam int unsigned DIST_W    = 24;
  localparam int unsigned TRI_IDX_W = 6;
  // centre deltas at or beyond 2^SPH_LIM_LOG2 always miss
  localparam int unsigned SPH_LIM_LOG2 = 24;
  localparam int unsigned SUM_W        = 2 * SPH_LIM_LOG2 + 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_I_CHK,
    S_I_TRI,
    S_I_PT,
    S_J_CHK,
    S_J_TRI,
    S_J_PT,
    S_SPH,
    S_EDGE,
    S_J_NEXT,
    S_EMIT
  } state_e;

endpackage

// ===== rtl/core/toc_if.sv =====
// ----------------------------------------------------------------------------
// Triangle overlap cull: channel interfaces
// Request channel (points and triangles) and result channel.
// ----------------------------------------------------------------------------
interface toc_in_if
  import toc_pkg::*;
#(
  parameter int unsigned CW = DEF_COORD_BITS
);
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic signed [CW-1:0]     coord_x;
  logic signed [CW-1:0]     coord_y;
  logic signed [CW-1:0]     coord_z;
  logic [VERT_W-1:0]        vert_a;
  logic [VERT_W-1:0]        vert_b;
  logic [VERT_W-1:0]        vert_c;
  logic [RAD_W-1:0]         bound_radius;
  logic [DIST_W-1:0]        view_distance;
  logic                     already_dead;
  logic                     last;

  modport source (output valid, req_type, coord_x, coord_y, coord_z, vert_a, vert_b,
                  vert_c, bound_radius, view_distance, already_dead, last,
                  input ready);
  modport sink   (input valid, req_type, coord_x, coord_y, coord_z, vert_a, vert_b,
                  vert_c, bound_radius, view_distance, already_dead, last,
                  output ready);
endinterface

interface toc_out_if
  import toc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [TRI_IDX_W-1:0] tri_index;
  logic                 is_dead;
  logic                 last_out;

  modport source (output valid, tri_index, is_dead, last_out, input ready);
  modport sink   (input valid, tri_index, is_dead, last_out, output ready);
endinterface

// ===== rtl/core/triangle_overlap_cull.sv =====
// ----------------------------------------------------------------------------
// Triangle overlap cull
// Loads points and triangles, then runs a pairwise overlap pass and reports
// the final dead flag of every triangle.
// ----------------------------------------------------------------------------
//  channel | dir | transaction
//  --------+-----+--------------------------------------------------------
//  req_i   | in  | one point (req_type 0) or one triangle (req_type 1)
//  res_o   | out | one triangle verdict: index, dead flag, last marker
//
//  Loads are taken back to back; req_i is ready only while idle.
//  A triangle with last set starts the pass: each live i is checked, its
//  record fetched and its three vertices read, and a dead i is skipped.
//  Each j is skipped if dead or if it shares a vertex, else it is fetched,
//  sphere-tested and updated; if the spheres meet, each edge of i is tried
//  against each edge of j until a pair meets, on one shared multiplier.
//  Results then leave at one per cycle, res_o stalls hold the sequencer.
//  Reset (rst_ni low, async) clears counts, dead flags and the sequencer;
//  the point and triangle stores are not cleared.
// ----------------------------------------------------------------------------
module triangle_overlap_cull
  import toc_pkg::*;
#(
  parameter int unsigned MAX_TRIANGLES = DEF_MAX_TRIANGLES,
  parameter int unsigned MAX_POINTS    = DEF_MAX_POINTS,
  parameter int unsigned COORD_BITS    = DEF_COORD_BITS
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  toc_in_if.sink   req_i,
  toc_out_if.source res_o
);

  localparam int unsigned CW     = COORD_BITS;
  localparam int unsigned TIW    = $clog2(MAX_TRIANGLES);
  localparam int unsigned TCW    = $clog2(MAX_TRIANGLES + 1);
  localparam int unsigned PAW    = $clog2(MAX_POINTS);
  localparam int unsigned PCW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned RS_W   = RAD_W + 2;          // signed radius sum
  localparam int unsigned OW     = (CW + 1 > RS_W) ? CW + 1 : RS_W;
  localparam int unsigned PW     = 2 * OW;
  // triangle record layout
  localparam int unsigned O_CX   = 3 * VERT_W;
  localparam int unsigned O_CY   = O_CX + CW;
  localparam int unsigned O_CZ   = O_CY + CW;
  localparam int unsigned O_RAD  = O_CZ + CW;
  localparam int unsigned O_DIST = O_RAD + RAD_W;
  localparam int unsigned TW     = O_DIST + DIST_W;

  // one bit wider than the deltas so the limit stays positive
  localparam logic signed [OW:0] SPH_LIM = (OW+1)'(1) << SPH_LIM_LOG2;

  // --------------------------------------------------------------------------
  // control state
  // --------------------------------------------------------------------------
  state_e             state_q, state_d;
  logic [TIW-1:0]     i_q;
  logic [TCW-1:0]     j_q;
  logic [TCW-1:0]     n_q;
  logic [1:0]         k_q;           // point fetch step
  logic [3:0]         s_q;           // multiply step
  logic [1:0]         e_q, f_q;      // edge of i, edge of j
  logic               hit_q;
  logic [PCW-1:0]     pt_cnt_q;
  logic [TCW-1:0]     tri_cnt_q;
  logic [MAX_TRIANGLES-1:0] dead_q;
  logic [3:0]         o_neg_q, o_zero_q;

  // datapath registers, no reset
  logic [TW-1:0]         ti_q, tj_q;
  logic signed [CW-1:0]  pix_q [3];
  logic signed [CW-1:0]  piy_q [3];
  logic signed [CW-1:0]  pjx_q [3];
  logic signed [CW-1:0]  pjy_q [3];
  logic                  oor_q;
  logic signed [PW-1:0]  p1_q;
  logic [SUM_W-1:0]      sum_q;

  // --------------------------------------------------------------------------
  // handshakes and stores
  // --------------------------------------------------------------------------
  logic in_acc, out_acc;
  logic pt_we, tri_we;
  logic [2*CW-1:0] pt_rdata;
  logic [TW-1:0]   tri_rdata;
  logic [PAW-1:0]  pt_raddr;
  logic [TIW-1:0]  tri_raddr;
  logic [VERT_W-1:0] vidx;
  logic              oor_d;

  assign req_i.ready = (state_q == S_IDLE);
  assign in_acc      = req_i.valid && req_i.ready;
  assign out_acc     = res_o.valid && res_o.ready;

  assign pt_we  = in_acc && !req_i.req_type && (pt_cnt_q < PCW'(MAX_POINTS));
  assign tri_we = in_acc && req_i.req_type && (tri_cnt_q < TCW'(MAX_TRIANGLES));

  toc_ram #(.WIDTH(2 * CW), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_cnt_q[PAW-1:0]),
    .wdata_i ({req_i.coord_y, req_i.coord_x}),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  toc_ram #(.WIDTH(TW), .DEPTH(MAX_TRIANGLES)) u_tri_ram (
    .clk_i   (clk_i),
    .we_i    (tri_we),
    .waddr_i (tri_cnt_q[TIW-1:0]),
    .wdata_i ({req_i.view_distance, req_i.bound_radius, req_i.coord_z, req_i.coord_y,
               req_i.coord_x, req_i.vert_c, req_i.vert_b, req_i.vert_a}),
    .raddr_i (tri_raddr),
    .rdata_o (tri_rdata)
  );

  assign tri_raddr = (state_q == S_J_CHK) ? j_q[TIW-1:0] : i_q;

  // vertex k of the triangle being fetched; beyond the store reads as origin
  always_comb begin
    logic [TW-1:0] rec;
    rec = (state_q == S_J_PT) ? tj_q : ti_q;
    case (k_q)
      2'd0:    vidx = rec[VERT_W-1:0];
      2'd1:    vidx = rec[2*VERT_W-1:VERT_W];
      default: vidx = rec[3*VERT_W-1:2*VERT_W];
    endcase
  end
  assign pt_raddr = PAW'(vidx);
  assign oor_d    = (32'(vidx) >= MAX_POINTS);

  logic signed [CW-1:0] rd_x, rd_y;
  assign rd_x = oor_q ? '0 : pt_rdata[CW-1:0];
  assign rd_y = oor_q ? '0 : pt_rdata[2*CW-1:CW];

  // shared-vertex test against the record just read
  logic share;
  always_comb begin
    share = 1'b0;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        if (ti_q[a*VERT_W +: VERT_W] == tri_rdata[b*VERT_W +: VERT_W]) begin
          share = 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // sphere operands
  // --------------------------------------------------------------------------
  logic signed [OW-1:0] dx, dy, dz, rsum;
  logic                 big;
  assign dx = OW'($signed(ti_q[O_CX +: CW])) - OW'($signed(tj_q[O_CX +: CW]));
  assign dy = OW'($signed(ti_q[O_CY +: CW])) - OW'($signed(tj_q[O_CY +: CW]));
  assign dz = OW'($signed(ti_q[O_CZ +: CW])) - OW'($signed(tj_q[O_CZ +: CW]));
  assign rsum = $signed(OW'(ti_q[O_RAD +: RAD_W])) + $signed(OW'(tj_q[O_RAD +: RAD_W]));
  assign big = ((OW+1)'(dx) >= SPH_LIM) || ((OW+1)'(dx) <= -SPH_LIM) ||
               ((OW+1)'(dy) >= SPH_LIM) || ((OW+1)'(dy) <= -SPH_LIM) ||
               ((OW+1)'(dz) >= SPH_LIM) || ((OW+1)'(dz) <= -SPH_LIM);

  // --------------------------------------------------------------------------
  // edge-pair endpoints: edges of i are 01 02 12, of j 01 02 21
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx_p, dy_p;
  always_comb begin
    case (e_q)
      2'd0: begin
        ax = pix_q[0]; ay = piy_q[0]; bx = pix_q[1]; by = piy_q[1];
      end
      2'd1: begin
        ax = pix_q[0]; ay = piy_q[0]; bx = pix_q[2]; by = piy_q[2];
      end
      default: begin
        ax = pix_q[1]; ay = piy_q[1]; bx = pix_q[2]; by = piy_q[2];
      end
    endcase
    case (f_q)
      2'd0: begin
        cx = pjx_q[0]; cy = pjy_q[0]; dx_p = pjx_q[1]; dy_p = pjy_q[1];
      end
      2'd1: begin
        cx = pjx_q[0]; cy = pjy_q[0]; dx_p = pjx_q[2]; dy_p = pjy_q[2];
      end
      default: begin
        cx = pjx_q[2]; cy = pjy_q[2]; dx_p = pjx_q[1]; dy_p = pjy_q[1];
      end
    endcase
  end

  // orientation k uses (P,Q,R) = (a,b,c) (a,b,d) (c,d,a) (c,d,b)
  logic signed [CW-1:0] px, py, qx, qy, rx, ry;
  always_comb begin
    case (s_q[2:1])
      2'd0: begin
        px = ax; py = ay; qx = bx; qy = by; rx = cx; ry = cy;
      end
      2'd1: begin
        px = ax; py = ay; qx = bx; qy = by; rx = dx_p; ry = dy_p;
      end
      2'd2: begin
        px = cx; py = cy; qx = dx_p; qy = dy_p; rx = ax; ry = ay;
      end
      default: begin
        px = cx; py = cy; qx = dx_p; qy = dy_p; rx = bx; ry = by;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // shared multiplier
  // --------------------------------------------------------------------------
  logic signed [OW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;

  always_comb begin
    mul_a = dx;
    mul_b = dx;
    if (state_q == S_SPH) begin
      case (s_q[1:0])
        2'd0:    begin mul_a = dx;   mul_b = dx;   end
        2'd1:    begin mul_a = dy;   mul_b = dy;   end
        2'd2:    begin mul_a = dz;   mul_b = dz;   end
        default: begin mul_a = rsum; mul_b = rsum; end
      endcase
    end else if (!s_q[0]) begin
      // first half of the cross product: (qx-px)(ry-py)
      mul_a = OW'(qx) - OW'(px);
      mul_b = OW'(ry) - OW'(py);
    end else begin
      // second half: (qy-py)(rx-px)
      mul_a = OW'(qy) - OW'(py);
      mul_b = OW'(rx) - OW'(px);
    end
  end

  toc_mul #(.OW(OW)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // segment test from the four stored orientations
  logic meet;
  always_comb begin
    logic [3:0] pos;
    logic       same12, same34, colin, box;
    pos    = ~o_neg_q & ~o_zero_q;
    same12 = (pos[0] && pos[1]) || (o_neg_q[0] && o_neg_q[1]);
    same34 = (pos[2] && pos[3]) || (o_neg_q[2] && o_neg_q[3]);
    colin  = &o_zero_q;
    box = ((ax >= cx) || (ax >= dx_p) || (bx >= cx) || (bx >= dx_p)) &&
          ((cx >= ax) || (cx >= bx) || (dx_p >= ax) || (dx_p >= bx)) &&
          ((ay >= cy) || (ay >= dy_p) || (by >= cy) || (by >= dy_p)) &&
          ((cy >= ay) || (cy >= by) || (dy_p >= ay) || (dy_p >= by));
    meet = !same12 && !same34 && (!colin || box);
  end

  // --------------------------------------------------------------------------
  // sequencer: next state
  // --------------------------------------------------------------------------
  logic i_done, j_done, last_res;
  assign i_done   = (TCW'(i_q) + TCW'(1)) >= n_q;
  assign j_done   = j_q >= n_q;
  assign last_res = (TCW'(i_q) + TCW'(1)) == n_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_acc && req_i.req_type && req_i.last) state_d = S_I_CHK;
      S_I_CHK: begin
        if (i_done) begin
          state_d = S_EMIT;
        end else if (!dead_q[i_q]) begin
          state_d = S_I_TRI;
        end
      end
      S_I_TRI:  state_d = S_I_PT;
      S_I_PT:   if (k_q == 2'd3) state_d = S_J_CHK;
      S_J_CHK: begin
        if (j_done) begin
          state_d = S_I_CHK;
        end else if (!dead_q[j_q[TIW-1:0]]) begin
          state_d = S_J_TRI;
        end
      end
      S_J_TRI:  state_d = share ? S_J_CHK : S_J_PT;
      S_J_PT:   if (k_q == 2'd3) state_d = S_SPH;
      S_SPH: begin
        if (s_q == 4'd4) begin
          state_d = (!big && (sum_q < prod[SUM_W-1:0])) ? S_EDGE : S_J_NEXT;
        end
      end
      S_EDGE: begin
        if (s_q == 4'd9 && (meet || (e_q == 2'd2 && f_q == 2'd2))) begin
          state_d = S_J_NEXT;
        end
      end
      S_J_NEXT: state_d = S_J_CHK;
      S_EMIT:   if (out_acc && last_res) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // counters, counts and dead flags
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q       <= '0;
      j_q       <= '0;
      n_q       <= '0;
      k_q       <= '0;
      s_q       <= '0;
      e_q       <= '0;
      f_q       <= '0;
      hit_q     <= 1'b0;
      pt_cnt_q  <= '0;
      tri_cnt_q <= '0;
      dead_q    <= '0;
      o_neg_q   <= '0;
      o_zero_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (pt_we) pt_cnt_q <= pt_cnt_q + PCW'(1);
          if (tri_we) begin
            dead_q[tri_cnt_q[TIW-1:0]] <= req_i.already_dead;
            tri_cnt_q <= tri_cnt_q + TCW'(1);
          end
          if (in_acc && req_i.req_type && req_i.last) begin
            n_q <= tri_we ? tri_cnt_q + TCW'(1) : tri_cnt_q;
            i_q <= '0;
          end
        end
        S_I_CHK: begin
          if (i_done) begin
            i_q <= '0;
          end else if (dead_q[i_q]) begin
            i_q <= i_q + TIW'(1);
          end
        end
        S_I_TRI: k_q <= '0;
        S_I_PT: begin
          k_q <= k_q + 2'd1;
          if (k_q == 2'd3) j_q <= TCW'(i_q) + TCW'(1);
        end
        S_J_CHK: begin
          if (j_done) begin
            i_q <= i_q + TIW'(1);
          end else if (dead_q[j_q[TIW-1:0]]) begin
            j_q <= j_q + TCW'(1);
          end
        end
        S_J_TRI: begin
          k_q <= '0;
          if (share) j_q <= j_q + TCW'(1);
        end
        S_J_PT: begin
          k_q <= k_q + 2'd1;
          s_q <= '0;
        end
        S_SPH: begin
          s_q   <= (s_q == 4'd4) ? 4'd0 : s_q + 4'd1;
          e_q   <= '0;
          f_q   <= '0;
          hit_q <= 1'b0;
        end
        S_EDGE: begin
          // orientation 0..3 completes at steps 2, 4, 6, 8
          if (s_q[0] == 1'b0 && s_q != 4'd0 && s_q != 4'd9 + 4'd1) begin
            o_neg_q[s_q[2:1] - 2'd1]  <= p1_q < prod;
            o_zero_q[s_q[2:1] - 2'd1] <= p1_q == prod;
          end
          if (s_q == 4'd9) begin
            s_q <= '0;
            if (meet) begin
              hit_q <= 1'b1;
            end else if (e_q == 2'd2) begin
              e_q <= '0;
              f_q <= f_q + 2'd1;
            end else begin
              e_q <= e_q + 2'd1;
            end
          end else begin
            s_q <= s_q + 4'd1;
          end
        end
        S_J_NEXT: begin
          if (hit_q) begin
            if (ti_q[O_DIST +: DIST_W] < tj_q[O_DIST +: DIST_W]) begin
              dead_q[i_q] <= 1'b1;
            end else begin
              dead_q[j_q[TIW-1:0]] <= 1'b1;
            end
          end
          j_q <= j_q + TCW'(1);
        end
        S_EMIT: begin
          if (out_acc) begin
            if (last_res) begin
              dead_q    <= '0;
              pt_cnt_q  <= '0;
              tri_cnt_q <= '0;
              i_q       <= '0;
            end else begin
              i_q <= i_q + TIW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // datapath captures
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    oor_q <= oor_d;
    p1_q  <= prod;
    case (state_q)
      S_I_TRI: ti_q <= tri_rdata;
      S_I_PT: begin
        if (k_q != 2'd0) begin
          pix_q[k_q - 2'd1] <= rd_x;
          piy_q[k_q - 2'd1] <= rd_y;
        end
      end
      S_J_TRI: tj_q <= tri_rdata;
      S_J_PT: begin
        if (k_q != 2'd0) begin
          pjx_q[k_q - 2'd1] <= rd_x;
          pjy_q[k_q - 2'd1] <= rd_y;
        end
      end
      S_SPH: begin
        // products of steps 0..2 arrive at 1..3
        if (s_q == 4'd1) begin
          sum_q <= prod[SUM_W-1:0];
        end else if (s_q == 4'd2 || s_q == 4'd3) begin
          sum_q <= sum_q + prod[SUM_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // results
  // --------------------------------------------------------------------------
  assign res_o.valid     = (state_q == S_EMIT);
  assign res_o.tri_index = TRI_IDX_W'(i_q);
  assign res_o.is_dead   = dead_q[i_q];
  assign res_o.last_out  = last_res;

endmodule

// ===== rtl/core/toc_ram.sv =====
// ----------------------------------------------------------------------------
// Triangle overlap cull: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module toc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/core/toc_mul.sv =====
// ----------------------------------------------------------------------------
// Triangle overlap cull: shared multiplier
// Signed multiply with the product registered, one result per cycle.
// ----------------------------------------------------------------------------
module toc_mul #(
  parameter int unsigned OW = 25
) (
  input  logic                   clk_i,
  input  logic signed [OW-1:0]   a_i,
  input  logic signed [OW-1:0]   b_i,
  output logic signed [2*OW-1:0] p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= (2*OW)'(a_i) * (2*OW)'(b_i);
  end

endmodule

// ===== rtl/core/toc_checker.sv =====
// ----------------------------------------------------------------------------
// Triangle overlap cull: port checker
// Watches the channel ports of the top level over time.
// ----------------------------------------------------------------------------
`include "triangle_overlap_cull_defines.svh"

module toc_checker
  import toc_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [TRI_IDX_W-1:0] out_index,
  input logic                 out_last
);

  // results stay offered until taken
  `TOC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid && $stable(out_index), "result dropped while stalled")

  // no new request while results are being reported
  `TOC_NEVER(a_busy_emit, clk_i, rst_ni, in_ready && out_valid, "ready while reporting")

  // results of a run come back to back in index order
  `TOC_ASSERT(a_order, clk_i, rst_ni, out_valid && out_ready && !out_last |=> out_valid && (out_index == $past(out_index) + 1'b1), "result index out of order")

  // the run closes after its last result
  `TOC_ASSERT(a_close, clk_i, rst_ni, out_valid && out_ready && out_last |=> !out_valid && in_ready, "run not closed after last result")

endmodule

bind triangle_overlap_cull toc_checker u_toc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (req_i.valid),
  .in_ready  (req_i.ready),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready),
  .out_index (res_o.tri_index),
  .out_last  (res_o.last_out)
);

// ===== tb/triangle_overlap_cull_tb.sv =====
// ----------------------------------------------------------------------------
// Triangle overlap cull: testbench
// Loads points and triangles through the request channel, predicts the final
// dead flag of every triangle with an exact integer model of the pair pass,
// and checks each verdict leaving the result channel in order.
// ----------------------------------------------------------------------------
module triangle_overlap_cull_tb;
  import toc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NPTS     = DEF_MAX_POINTS;
  localparam int unsigned NTRIS    = DEF_MAX_TRIANGLES;
  localparam int unsigned CW       = DEF_COORD_BITS;
  localparam int unsigned WD_LIMIT = 600000; // longest quiet stretch the watchdog allows
  localparam int unsigned HOLD_LEN = 1500;
  localparam bit          REQ_POINT = 1'b0;
  localparam bit          REQ_TRI   = 1'b1;

  typedef struct {
    bit                   req_type;
    logic signed [CW-1:0] x, y, z;
    bit [VERT_W-1:0]      va, vb, vc;
    bit [RAD_W-1:0]       rad;
    bit [DIST_W-1:0]      vdist;
    bit                   dead;
    bit                   last;
  } load_t;

  typedef struct {
    bit [TRI_IDX_W-1:0] idx;
    bit                 dead;
    bit                 last;
  } verdict_t;

  // predicts the verdicts of one pass and checks them in order
  class cull_scoreboard;
    longint   pxs[NPTS], pys[NPTS];
    int       tvert[NTRIS][3];
    longint   cxs[NTRIS], cys[NTRIS], czs[NTRIS];
    longint   rads[NTRIS], dists[NTRIS];
    bit       dflag[NTRIS];
    int       pcnt, tcnt;
    verdict_t verdicts_due[$];
    int       errors;

    function int orient(longint ax, ay, bx, by, qx, qy);
      longint v;
      v = (bx - ax) * (qy - ay) - (by - ay) * (qx - ax);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function bit segs_meet(longint ax, ay, bx, by, qx, qy, rx, ry);
      int o1, o2, o3, o4;
      o1 = orient(ax, ay, bx, by, qx, qy);
      o2 = orient(ax, ay, bx, by, rx, ry);
      o3 = orient(qx, qy, rx, ry, ax, ay);
      o4 = orient(qx, qy, rx, ry, bx, by);
      if (o1 * o2 > 0 || o3 * o4 > 0) return 0;
      if (o1 == 0 && o2 == 0 && o3 == 0 && o4 == 0) begin
        // collinear: extents must overlap on both axes, touching counts
        return ((ax > bx ? ax : bx) >= (qx < rx ? qx : rx)) &&
               ((qx > rx ? qx : rx) >= (ax < bx ? ax : bx)) &&
               ((ay > by ? ay : by) >= (qy < ry ? qy : ry)) &&
               ((qy > ry ? qy : ry) >= (ay < by ? ay : by));
      end
      return 1;
    endfunction

    function bit spheres_meet(int i, int j);
      longint d[3];
      longint sum, r, m;
      d[0] = cxs[i] - cxs[j];
      d[1] = cys[i] - cys[j];
      d[2] = czs[i] - czs[j];
      sum  = 0;
      r    = rads[i] + rads[j];
      for (int k = 0; k < 3; k++) begin
        m = d[k] < 0 ? -d[k] : d[k];
        if (m >= (64'sd1 <<< 24)) return 0;
        sum += m * m;
      end
      return sum < r * r;
    endfunction

    function bit tris_cross(int i, int j);
      int ea[3] = '{0, 0, 1};
      int eb[3] = '{1, 2, 2};
      int fa[3] = '{0, 0, 2};
      int fb[3] = '{1, 2, 1};
      int p, q, s, t;
      for (int f = 0; f < 3; f++)
        for (int e = 0; e < 3; e++) begin
          p = tvert[i][ea[e]]; q = tvert[i][eb[e]];
          s = tvert[j][fa[f]]; t = tvert[j][fb[f]];
          if (segs_meet(pxs[p], pys[p], pxs[q], pys[q], pxs[s], pys[s], pxs[t], pys[t]))
            return 1;
        end
      return 0;
    endfunction

    function bit share_vertex(int i, int j);
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++)
          if (tvert[i][a] == tvert[j][b]) return 1;
      return 0;
    endfunction

    function void note_load(load_t it);
      verdict_t v;
      if (it.req_type == REQ_POINT) begin
        if (pcnt < NPTS) begin
          pxs[pcnt] = longint'(it.x);
          pys[pcnt] = longint'(it.y);
          pcnt++;
        end
        return;
      end
      if (tcnt < NTRIS) begin
        tvert[tcnt][0] = int'(it.va); tvert[tcnt][1] = int'(it.vb);
        tvert[tcnt][2] = int'(it.vc);
        cxs[tcnt] = longint'(it.x); cys[tcnt] = longint'(it.y); czs[tcnt] = longint'(it.z);
        rads[tcnt] = longint'(it.rad); dists[tcnt] = longint'(it.vdist);
        dflag[tcnt] = it.dead;
        tcnt++;
      end
      if (!it.last) return;
      for (int i = 0; i + 1 < tcnt; i++) begin
        if (dflag[i]) continue;
        // i may die mid-loop and still goes on testing later j
        for (int j = i + 1; j < tcnt; j++) begin
          if (dflag[j] || share_vertex(i, j)) continue;
          if (spheres_meet(i, j) && tris_cross(i, j)) begin
            if (dists[i] < dists[j]) dflag[i] = 1;
            else dflag[j] = 1;
          end
        end
      end
      for (int i = 0; i < tcnt; i++) begin
        v.idx  = TRI_IDX_W'(i);
        v.dead = dflag[i];
        v.last = (i + 1 == tcnt);
        verdicts_due.push_back(v);
        dflag[i] = 0;
      end
      pcnt = 0;
      tcnt = 0;
    endfunction

    task report(string msg);
      $display("%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_verdict(verdict_t got);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        report($sformatf("unexpected verdict for triangle %0d", got.idx));
        return;
      end
      want = verdicts_due.pop_front();
      if (got.idx != want.idx)
        report($sformatf("tri_index got %0d want %0d", got.idx, want.idx));
      if (got.dead != want.dead)
        report($sformatf("is_dead of %0d got %0d want %0d", want.idx, got.dead, want.dead));
      if (got.last != want.last)
        report($sformatf("last_out of %0d got %0d want %0d", want.idx, got.last, want.last));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  toc_in_if #(.CW(CW)) req ();
  toc_out_if           res ();

  triangle_overlap_cull i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (res)
  );

  cull_scoreboard sb = new();

  int idle_pct;          // sender gap chance per cycle, in percent
  int stall_pct;         // receiver stall chance per cycle, in percent
  bit hold_pending;      // one long receiver hold-off on the next verdict
  int rand_items;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // monitor: sample both channels at the rising edge, plus the watchdog
  initial begin
    load_t    it;
    verdict_t got;
    int       quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && req.valid && req.ready) begin
        it.req_type = req.req_type;
        it.x = req.coord_x; it.y = req.coord_y; it.z = req.coord_z;
        it.va = req.vert_a; it.vb = req.vert_b; it.vc = req.vert_c;
        it.rad = req.bound_radius; it.vdist = req.view_distance;
        it.dead = req.already_dead; it.last = req.last;
        sb.note_load(it);
        quiet = 0;
      end else if (rst_ni && res.valid && res.ready) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (rst_ni && res.valid && res.ready) begin
        got.idx = res.tri_index; got.dead = res.is_dead; got.last = res.last_out;
        sb.check_verdict(got);
      end
      if (quiet >= WD_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // receiver: random stalls, and the one long hold-off that backs the block up
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_pending && res.valid) begin
        res.ready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk_i);
        hold_pending = 0;
      end
      res.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(load_t it);
    while ($urandom_range(99) < idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk_i);
    end
    req.req_type = it.req_type;
    req.coord_x = it.x; req.coord_y = it.y; req.coord_z = it.z;
    req.vert_a = it.va; req.vert_b = it.vb; req.vert_c = it.vc;
    req.bound_radius = it.rad; req.view_distance = it.vdist;
    req.already_dead = it.dead; req.last = it.last;
    req.valid = 1'b1;
    do @(posedge clk_i); while (!req.ready);
    @(negedge clk_i);
  endtask

  task automatic send_point(int x, int y);
    load_t it;
    it = '{default: 0};
    it.req_type = REQ_POINT;
    it.x = CW'(x); it.y = CW'(y); it.z = CW'($urandom());
    it.last = 1'($urandom_range(1));
    send_item(it);
  endtask

  task automatic send_tri(int a, int b, int c, int x, int y, int z,
                          int rad, int vdist, bit dead, bit last);
    load_t it;
    it.req_type = REQ_TRI;
    it.va = VERT_W'(a); it.vb = VERT_W'(b); it.vc = VERT_W'(c);
    it.x = CW'(x); it.y = CW'(y); it.z = CW'(z);
    it.rad = RAD_W'(rad); it.vdist = DIST_W'(vdist);
    it.dead = dead; it.last = last;
    send_item(it);
  endtask

  function automatic int near(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // small well-formed run: points of this run sit at store slots 0..npts-1
  task automatic random_run();
    int npts, ntri, span, v[3];
    bit wild;
    npts = $urandom_range(3, 8);
    ntri = ($urandom_range(9) == 0) ? $urandom_range(10, 16) : $urandom_range(2, 6);
    span = ($urandom_range(3) == 0) ? 256 : 1024;
    for (int p = 0; p < npts; p++) begin
      if ($urandom_range(9) == 0) send_point($urandom(), $urandom());
      else send_point(near(span), near(span));
      rand_items++;
    end
    for (int t = 0; t < ntri; t++) begin
      wild = ($urandom_range(9) == 0);
      for (int k = 0; k < 3; k++)
        v[k] = wild ? $urandom_range(NPTS - 1) : $urandom_range(npts - 1);
      if (wild)
        send_tri(v[0], v[1], v[2], $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), 1'($urandom_range(1)), t == ntri - 1);
      else
        send_tri(v[0], v[1], v[2], near(span), near(span), near(span),
                 $urandom_range(0, 4 * span),
                 ($urandom_range(1) ? $urandom_range(7) : $urandom()),
                 $urandom_range(7) == 0, t == ntri - 1);
      rand_items++;
    end
  endtask

  initial begin
    int run_no;
    rst_ni       = 1'b0;
    req.valid    = 1'b0;
    req.req_type = REQ_POINT;
    req.coord_x = '0; req.coord_y = '0; req.coord_z = '0;
    req.vert_a = '0; req.vert_b = '0; req.vert_c = '0;
    req.bound_radius = '0; req.view_distance = '0;
    req.already_dead = 1'b0; req.last = 1'b0;
    res.ready    = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_pending = 0;
    rand_items   = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: coordinate extremes, duplicate points, collinear and
    // degenerate edges, shared vertices, radius and distance extremes
    send_point(-8388608, 8388607);
    send_point(8388607, -8388608);
    send_point(0, 0);
    send_point(256, 0);
    send_point(0, 256);
    send_point(256, 256);
    send_point(0, 0);
    send_point(512, 512);
    send_point(-1, -1);
    send_tri(2, 3, 4, 0, 0, 0, 4096, 100, 0, 0);
    send_tri(5, 6, 7, 0, 0, 0, 4096, 50, 0, 0);        // collinear, touches t0
    send_tri(0, 1, 2, -8388608, 8388607, 8388607, 8388607, 16777215, 0, 0);
    send_tri(3, 3, 3, 0, 0, 0, 0, 0, 1, 0);            // point triangle, starts dead
    send_tri(7, 7, 1, 0, 0, -8388608, 8388607, 0, 0, 0);
    send_tri(8, 6, 3, 1, 1, 1, 8388607, 100, 0, 0);    // equal distances
    send_tri(0, 1, 8, 8388607, -8388608, 8388607, 8388607, 16777215, 0, 1);

    // both stores overfilled: the 257th point and 65th triangle are dropped,
    // the dropped triangle's last flag still starts the pass
    for (int p = 0; p <= NPTS; p++) send_point($urandom(), $urandom());
    for (int t = 0; t <= NTRIS; t++)
      send_tri($urandom_range(NPTS - 1), $urandom_range(NPTS - 1), $urandom_range(NPTS - 1),
               near(65536), near(65536), near(65536), $urandom_range(0, 1 << 17),
               $urandom(), $urandom_range(7) == 0, t == NTRIS);

    // random runs, rotating through the idling phases
    run_no = 0;
    while (rand_items < 110) begin
      case (run_no % 5)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        3: begin idle_pct = 10; stall_pct = 10; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      if (run_no == 3) hold_pending = 1;
      random_run();
      run_no++;
    end
    req.valid = 1'b0;

    while (sb.verdicts_due.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
